>>> src/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg: shared types and constants of the dictionary matcher
// Node geometry, node record layout, item modes, sequencer states.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int NODES    = 4096;
  localparam int ALPHABET = 26;
  localparam int SLOTS    = NODES * ALPHABET;

  localparam int NODE_W = $clog2(NODES);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SYM_W  = 5;
  localparam int MODE_W = 2;
  localparam int END_W  = 16;
  localparam int CNT_W  = 20;
  localparam int PTR_W  = NODE_W + 1;

  localparam logic [END_W-1:0] END_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PATTERN = 2'd0,
    MODE_BUILD   = 2'd1,
    MODE_TEXT    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // one trie node record
  typedef struct packed {
    logic [NODE_W-1:0] parent;
    logic [SYM_W-1:0]  psym;
    logic [END_W-1:0]  ecnt;
    logic [NODE_W-1:0] olink;
    logic [NODE_W-1:0] flink;
  } node_t;

  localparam int NODE_REC_W = $bits(node_t);

  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] count;
    logic             full;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_P_G,
    ST_P_CK,
    ST_P_LAST,
    ST_P_INC,
    ST_T_G,
    ST_T_C,
    ST_T_CH,
    ST_T_LAST,
    ST_B_INIT,
    ST_B_Q,
    ST_B_QW,
    ST_B_UW,
    ST_B_G,
    ST_B_GW,
    ST_B_CK,
    ST_B_FW
  } state_t;

  function automatic logic [SLOT_W-1:0] slot(input logic [NODE_W-1:0] node,
                                             input logic [SYM_W-1:0]  sym);
    logic [SLOT_W-1:0] base;
    base = SLOT_W'(node) * SLOT_W'(ALPHABET);
    return base + SLOT_W'(sym);
  endfunction

endpackage

>>> src/mpsm_ram.sv
// ----------------------------------------------------------------------------
// mpsm_ram: generic single write port, single read port RAM
// Read data is registered, old data on collision.
// ----------------------------------------------------------------------------
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/mpsm_ctrl.sv
// ----------------------------------------------------------------------------
// mpsm_ctrl: sequencer of the matcher
// Insert, build and scan walks over the goto, node and queue memories.
// ----------------------------------------------------------------------------
module mpsm_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  output logic                            in_rdy,
  input  logic [mpsm_pkg::MODE_W-1:0]     in_mode,
  input  logic [mpsm_pkg::SYM_W-1:0]      in_sym,
  input  logic                            in_last,
  input  logic                            out_full,
  output mpsm_pkg::res_t                  res,
  output logic                            g_we,
  output logic [mpsm_pkg::SLOT_W-1:0]     g_waddr,
  output logic [mpsm_pkg::NODE_W-1:0]     g_wdata,
  output logic [mpsm_pkg::SLOT_W-1:0]     g_raddr,
  input  logic [mpsm_pkg::NODE_W-1:0]     g_rdata,
  output logic                            n_we,
  output logic [mpsm_pkg::NODE_W-1:0]     n_waddr,
  output mpsm_pkg::node_t                 n_wdata,
  output logic [mpsm_pkg::NODE_W-1:0]     n_raddr,
  input  mpsm_pkg::node_t                 n_rdata,
  output logic                            q_we,
  output logic [mpsm_pkg::NODE_W-1:0]     q_waddr,
  output logic [mpsm_pkg::NODE_W-1:0]     q_wdata,
  output logic [mpsm_pkg::NODE_W-1:0]     q_raddr,
  input  logic [mpsm_pkg::NODE_W-1:0]     q_rdata
);

  mpsm_pkg::state_t state_r, state_nxt;

  logic [mpsm_pkg::NODE_W-1:0] ins_r, ins_nxt;
  logic [mpsm_pkg::NODE_W-1:0] scan_r, scan_nxt;
  logic [mpsm_pkg::NODE_W-1:0] nt_r, nt_nxt;
  logic [mpsm_pkg::CNT_W-1:0]  total_r, total_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        drop_r, drop_nxt;
  logic [mpsm_pkg::SYM_W-1:0]  sym_r, sym_nxt;
  logic                        last_r, last_nxt;
  logic [mpsm_pkg::NODE_W-1:0] v_r, v_nxt;
  logic [mpsm_pkg::NODE_W-1:0] u_r, u_nxt;
  logic [mpsm_pkg::NODE_W-1:0] fu_r, fu_nxt;
  logic [mpsm_pkg::NODE_W-1:0] f_r, f_nxt;
  mpsm_pkg::node_t             nd_r, nd_nxt;
  logic [mpsm_pkg::SYM_W-1:0]  s_r, s_nxt;
  logic [mpsm_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [mpsm_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [mpsm_pkg::PTR_W-1:0]  guard_r, guard_nxt;
  logic [mpsm_pkg::SLOT_W-1:0] clr_r, clr_nxt;
  logic                        pwe_r;
  logic [mpsm_pkg::NODE_W-1:0] pwa_r;

  logic                        acc;
  logic                        in_ok;
  logic                        child_p;
  logic                        child_b;
  logic                        room;
  logic [mpsm_pkg::NODE_W-1:0] new_node;
  logic [mpsm_pkg::NODE_W-1:0] f_sel;
  logic [mpsm_pkg::END_W-1:0]  ch_end;
  logic [mpsm_pkg::CNT_W:0]    sum_c;
  logic [mpsm_pkg::CNT_W:0]    sum_ch;
  logic [mpsm_pkg::CNT_W-1:0]  tot_c;
  logic [mpsm_pkg::CNT_W-1:0]  tot_ch;
  logic                        chain_go;
  logic                        s_end;

  assign acc     = in_vld && in_rdy;
  assign in_ok   = in_sym < mpsm_pkg::SYM_W'(mpsm_pkg::ALPHABET);
  assign child_p = (v_r != '0) && (n_rdata.parent == ins_r) && (n_rdata.psym == sym_r);
  assign child_b = (v_r != '0) && (n_rdata.parent == u_r) && (n_rdata.psym == s_r);
  assign room    = ({1'b0, nt_r} + mpsm_pkg::PTR_W'(1)) < mpsm_pkg::PTR_W'(mpsm_pkg::NODES);
  assign new_node = nt_r + mpsm_pkg::NODE_W'(1);
  assign f_sel   = (u_r != '0) ? g_rdata : '0;
  // a node written in the cycle before reads stale: its count is already cleared
  assign ch_end  = (pwe_r && pwa_r == v_r) ? '0 : n_rdata.ecnt;
  assign sum_c   = {1'b0, total_r} + mpsm_pkg::CNT_W'(n_rdata.ecnt);
  assign sum_ch  = {1'b0, total_r} + mpsm_pkg::CNT_W'(ch_end);
  assign tot_c   = (sum_c > {1'b0, mpsm_pkg::CNT_MAX}) ? mpsm_pkg::CNT_MAX
                                                      : sum_c[mpsm_pkg::CNT_W-1:0];
  assign tot_ch  = (sum_ch > {1'b0, mpsm_pkg::CNT_MAX}) ? mpsm_pkg::CNT_MAX
                                                       : sum_ch[mpsm_pkg::CNT_W-1:0];
  assign chain_go = (n_rdata.olink != '0) &&
                    ((guard_r + mpsm_pkg::PTR_W'(1)) < mpsm_pkg::PTR_W'(mpsm_pkg::NODES));
  assign s_end   = s_r == mpsm_pkg::SYM_W'(mpsm_pkg::ALPHABET - 1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpsm_pkg::ST_CLR: begin
        if (clr_r == mpsm_pkg::SLOT_W'(mpsm_pkg::SLOTS - 1)) state_nxt = mpsm_pkg::ST_IDLE;
      end
      mpsm_pkg::ST_IDLE: begin
        if (acc) begin
          case (mpsm_pkg::mode_t'(in_mode))
            mpsm_pkg::MODE_PATTERN: begin
              if (in_ok && !drop_r) state_nxt = mpsm_pkg::ST_P_G;
              else if (in_last)     state_nxt = mpsm_pkg::ST_P_LAST;
            end
            mpsm_pkg::MODE_BUILD: state_nxt = mpsm_pkg::ST_B_INIT;
            mpsm_pkg::MODE_TEXT: begin
              if (in_ok)        state_nxt = mpsm_pkg::ST_T_G;
              else if (in_last) state_nxt = mpsm_pkg::ST_T_LAST;
            end
            default: state_nxt = mpsm_pkg::ST_IDLE;
          endcase
        end
      end
      mpsm_pkg::ST_P_G:    state_nxt = mpsm_pkg::ST_P_CK;
      mpsm_pkg::ST_P_CK:   state_nxt = last_r ? mpsm_pkg::ST_P_LAST : mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_P_LAST: state_nxt = drop_r ? mpsm_pkg::ST_IDLE : mpsm_pkg::ST_P_INC;
      mpsm_pkg::ST_P_INC:  state_nxt = mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_T_G:    state_nxt = mpsm_pkg::ST_T_C;
      mpsm_pkg::ST_T_C, mpsm_pkg::ST_T_CH: begin
        if (state_r == mpsm_pkg::ST_T_C ? (n_rdata.olink != '0) : chain_go)
          state_nxt = mpsm_pkg::ST_T_CH;
        else
          state_nxt = last_r ? mpsm_pkg::ST_T_LAST : mpsm_pkg::ST_IDLE;
      end
      mpsm_pkg::ST_T_LAST: if (!out_full) state_nxt = mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_B_INIT: state_nxt = mpsm_pkg::ST_B_Q;
      mpsm_pkg::ST_B_Q:    state_nxt = (head_r < tail_r) ? mpsm_pkg::ST_B_QW
                                                         : mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_B_QW:   state_nxt = mpsm_pkg::ST_B_UW;
      mpsm_pkg::ST_B_UW:   state_nxt = mpsm_pkg::ST_B_G;
      mpsm_pkg::ST_B_G:    state_nxt = mpsm_pkg::ST_B_GW;
      mpsm_pkg::ST_B_GW:   state_nxt = mpsm_pkg::ST_B_CK;
      mpsm_pkg::ST_B_CK: begin
        if (child_b)    state_nxt = mpsm_pkg::ST_B_FW;
        else if (s_end) state_nxt = mpsm_pkg::ST_B_Q;
        else            state_nxt = mpsm_pkg::ST_B_G;
      end
      mpsm_pkg::ST_B_FW:   state_nxt = s_end ? mpsm_pkg::ST_B_Q : mpsm_pkg::ST_B_G;
      default:             state_nxt = mpsm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_rdy    = 1'b0;
    res       = '0;
    res.count = total_r;
    res.full  = ovf_r;
    g_we      = 1'b0;
    g_waddr   = '0;
    g_wdata   = '0;
    g_raddr   = '0;
    n_we      = 1'b0;
    n_waddr   = '0;
    n_wdata   = '0;
    n_raddr   = '0;
    q_we      = 1'b0;
    q_waddr   = '0;
    q_wdata   = '0;
    q_raddr   = '0;
    ins_nxt   = ins_r;
    scan_nxt  = scan_r;
    nt_nxt    = nt_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    drop_nxt  = drop_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    v_nxt     = v_r;
    u_nxt     = u_r;
    fu_nxt    = fu_r;
    f_nxt     = f_r;
    nd_nxt    = nd_r;
    s_nxt     = s_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    guard_nxt = guard_r;
    clr_nxt   = clr_r;
    case (state_r)
      mpsm_pkg::ST_CLR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        n_we    = clr_r < mpsm_pkg::SLOT_W'(mpsm_pkg::NODES);
        n_waddr = clr_r[mpsm_pkg::NODE_W-1:0];
        clr_nxt = clr_r + mpsm_pkg::SLOT_W'(1);
      end
      mpsm_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ok) begin
          g_raddr = mpsm_pkg::slot((mpsm_pkg::mode_t'(in_mode) == mpsm_pkg::MODE_TEXT)
                                   ? scan_r : ins_r, in_sym);
        end
        if (acc) begin
          sym_nxt  = in_sym;
          last_nxt = in_last;
        end
      end
      mpsm_pkg::ST_P_G: begin
        v_nxt   = g_rdata;
        n_raddr = g_rdata;
      end
      mpsm_pkg::ST_P_CK: begin
        if (child_p) begin
          ins_nxt = v_r;
        end else if (!room) begin
          ovf_nxt  = 1'b1;
          drop_nxt = 1'b1;
        end else begin
          nt_nxt         = new_node;
          ins_nxt        = new_node;
          n_we           = 1'b1;
          n_waddr        = new_node;
          n_wdata.parent = ins_r;
          n_wdata.psym   = sym_r;
          g_we           = 1'b1;
          g_waddr        = mpsm_pkg::slot(ins_r, sym_r);
          g_wdata        = new_node;
        end
      end
      mpsm_pkg::ST_P_LAST: begin
        n_raddr = ins_r;
        if (drop_r) begin
          ins_nxt  = '0;
          drop_nxt = 1'b0;
        end
      end
      mpsm_pkg::ST_P_INC: begin
        n_waddr = ins_r;
        n_wdata = n_rdata;
        if (n_rdata.ecnt < mpsm_pkg::END_MAX) begin
          n_we         = 1'b1;
          n_wdata.ecnt = n_rdata.ecnt + mpsm_pkg::END_W'(1);
        end
        ins_nxt  = '0;
        drop_nxt = 1'b0;
      end
      mpsm_pkg::ST_T_G: begin
        scan_nxt = g_rdata;
        n_raddr  = g_rdata;
      end
      mpsm_pkg::ST_T_C: begin
        total_nxt    = tot_c;
        n_we         = 1'b1;
        n_waddr      = scan_r;
        n_wdata      = n_rdata;
        n_wdata.ecnt = '0;
        n_raddr      = n_rdata.olink;
        v_nxt        = n_rdata.olink;
        guard_nxt    = '0;
      end
      mpsm_pkg::ST_T_CH: begin
        total_nxt    = tot_ch;
        n_we         = 1'b1;
        n_waddr      = v_r;
        n_wdata      = n_rdata;
        n_wdata.ecnt = '0;
        n_raddr      = n_rdata.olink;
        v_nxt        = n_rdata.olink;
        guard_nxt    = guard_r + mpsm_pkg::PTR_W'(1);
      end
      mpsm_pkg::ST_T_LAST: begin
        if (!out_full) begin
          res.vld   = 1'b1;
          total_nxt = '0;
          scan_nxt  = '0;
        end
      end
      mpsm_pkg::ST_B_INIT: begin
        q_we     = 1'b1;
        head_nxt = '0;
        tail_nxt = mpsm_pkg::PTR_W'(1);
      end
      mpsm_pkg::ST_B_Q: begin
        q_raddr = head_r[mpsm_pkg::NODE_W-1:0];
        if (head_r < tail_r) begin
          head_nxt = head_r + mpsm_pkg::PTR_W'(1);
        end else begin
          scan_nxt  = '0;
          total_nxt = '0;
        end
      end
      mpsm_pkg::ST_B_QW: begin
        u_nxt   = q_rdata;
        n_raddr = q_rdata;
      end
      mpsm_pkg::ST_B_UW: begin
        fu_nxt = n_rdata.flink;
        s_nxt  = '0;
      end
      mpsm_pkg::ST_B_G: begin
        g_raddr = mpsm_pkg::slot(u_r, s_r);
      end
      mpsm_pkg::ST_B_GW: begin
        v_nxt   = g_rdata;
        n_raddr = g_rdata;
        g_raddr = mpsm_pkg::slot(fu_r, s_r);
      end
      mpsm_pkg::ST_B_CK: begin
        nd_nxt = n_rdata;
        f_nxt  = f_sel;
        if (child_b) begin
          n_raddr = f_sel;
        end else begin
          g_we    = 1'b1;
          g_waddr = mpsm_pkg::slot(u_r, s_r);
          g_wdata = f_sel;
          s_nxt   = s_r + mpsm_pkg::SYM_W'(1);
        end
      end
      mpsm_pkg::ST_B_FW: begin
        n_we          = 1'b1;
        n_waddr       = v_r;
        n_wdata       = nd_r;
        n_wdata.flink = f_r;
        n_wdata.olink = (n_rdata.ecnt != '0) ? f_r : n_rdata.olink;
        if (tail_r < mpsm_pkg::PTR_W'(mpsm_pkg::NODES)) begin
          q_we     = 1'b1;
          q_waddr  = tail_r[mpsm_pkg::NODE_W-1:0];
          q_wdata  = v_r;
          tail_nxt = tail_r + mpsm_pkg::PTR_W'(1);
        end
        s_nxt = s_r + mpsm_pkg::SYM_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpsm_pkg::ST_CLR;
      clr_r   <= '0;
      ins_r   <= '0;
      scan_r  <= '0;
      nt_r    <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
      drop_r  <= 1'b0;
      pwe_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ins_r   <= ins_nxt;
      scan_r  <= scan_nxt;
      nt_r    <= nt_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      drop_r  <= drop_nxt;
      pwe_r   <= n_we;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    last_r  <= last_nxt;
    v_r     <= v_nxt;
    u_r     <= u_nxt;
    fu_r    <= fu_nxt;
    f_r     <= f_nxt;
    nd_r    <= nd_nxt;
    s_r     <= s_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    guard_r <= guard_nxt;
    pwa_r   <= n_waddr;
  end

endmodule

>>> src/multi_pattern_string_matcher_top.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_top: Aho-Corasick matcher over 26 letters
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   tdata: symbol[4:0]; tuser: mode[1:0]; tlast: last
//   out_     out  out_tvalid/out_tready tdata: match_count[19:0] trie_full[20]
//
// A pattern letter takes a goto read and a child check; closing a pattern adds
// a node read and, unless dropped, the count update. A text letter takes a goto
// read and a node update, plus a chain step per output-link hop; closing a text
// adds the result state. A build reads the queue and a node per queued node,
// two goto entries and a check per letter slot, and writes a node per trie edge.
// After reset a clearing pass sweeps the goto and node memories; in_tready
// stays low meanwhile. A held result stalls only the word that closes a text.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[4:0]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // match_count[19:0], trie_full[20]
);

  mpsm_pkg::res_t res;

  logic                          out_full;
  logic                          out_tvalid_r;
  logic [mpsm_pkg::CNT_W-1:0]    count_r;
  logic                          full_r;

  logic                          g_we;
  logic [mpsm_pkg::SLOT_W-1:0]   g_waddr;
  logic [mpsm_pkg::NODE_W-1:0]   g_wdata;
  logic [mpsm_pkg::SLOT_W-1:0]   g_raddr;
  logic [mpsm_pkg::NODE_W-1:0]   g_rdata;
  logic                          n_we;
  logic [mpsm_pkg::NODE_W-1:0]   n_waddr;
  mpsm_pkg::node_t               n_wdata;
  logic [mpsm_pkg::NODE_W-1:0]   n_raddr;
  mpsm_pkg::node_t               n_rdata;
  logic                          q_we;
  logic [mpsm_pkg::NODE_W-1:0]   q_waddr;
  logic [mpsm_pkg::NODE_W-1:0]   q_wdata;
  logic [mpsm_pkg::NODE_W-1:0]   q_raddr;
  logic [mpsm_pkg::NODE_W-1:0]   q_rdata;

  assign out_full = out_tvalid_r && !out_tready;

  mpsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_tvalid),
    .in_rdy   (in_tready),
    .in_mode  (in_tuser),
    .in_sym   (in_tdata[4:0]),
    .in_last  (in_tlast),
    .out_full (out_full),
    .res      (res),
    .g_we     (g_we),
    .g_waddr  (g_waddr),
    .g_wdata  (g_wdata),
    .g_raddr  (g_raddr),
    .g_rdata  (g_rdata),
    .n_we     (n_we),
    .n_waddr  (n_waddr),
    .n_wdata  (n_wdata),
    .n_raddr  (n_raddr),
    .n_rdata  (n_rdata),
    .q_we     (q_we),
    .q_waddr  (q_waddr),
    .q_wdata  (q_wdata),
    .q_raddr  (q_raddr),
    .q_rdata  (q_rdata)
  );

  mpsm_ram #(.WIDTH(mpsm_pkg::NODE_W), .DEPTH(mpsm_pkg::SLOTS)) u_goto (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  mpsm_ram #(.WIDTH(mpsm_pkg::NODE_REC_W), .DEPTH(mpsm_pkg::NODES)) u_node (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  mpsm_ram #(.WIDTH(mpsm_pkg::NODE_W), .DEPTH(mpsm_pkg::NODES)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res.vld) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      count_r <= res.count;
      full_r  <= res.full;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, full_r, count_r};

endmodule

>>> tb/tb_multi_pattern_string_matcher_top.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_string_matcher_top: self-checking bench of the matcher
// Pattern, build and text words go in through the input stream. A behavioral
// copy of the automaton predicts each match total, and every result word is
// compared with the oldest prediction. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module tb_multi_pattern_string_matcher_top;

  localparam int WDOG_LIMIT = 600000;
  localparam int TAIL_WAIT  = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  multi_pattern_string_matcher_top u_dut (.*);

  always #5 clk = ~clk;

  // behavioral automaton
  int unsigned goto_nx [mpsm_pkg::SLOTS];
  int unsigned fail_nx [mpsm_pkg::NODES];
  int unsigned dict_nx [mpsm_pkg::NODES];
  int unsigned hits    [mpsm_pkg::NODES];
  int unsigned up_node [mpsm_pkg::NODES];
  int unsigned up_sym  [mpsm_pkg::NODES];
  int unsigned used_nodes, put_node, walk_node, total_hits;
  bit          trie_over, drop_pat;

  typedef struct {
    logic [mpsm_pkg::CNT_W-1:0] count;
    logic                       full;
  } total_t;
  total_t totals_q[$];

  int  errors = 0;
  int  burst_left = 0;
  bit  quiet_rx = 1'b0;
  int  rx_phase = 0;
  int  wdog = 0;

  function automatic bit trie_edge(int unsigned u, int unsigned s, int unsigned v);
    return v != 0 && v < mpsm_pkg::NODES && up_node[v] == u && up_sym[v] == s;
  endfunction

  function automatic void take_hits(int unsigned n);
    total_hits += hits[n];
    if (total_hits > mpsm_pkg::CNT_MAX) total_hits = mpsm_pkg::CNT_MAX;
    hits[n] = 0;
  endfunction

  function automatic void build_links();
    int unsigned bq[$];
    int unsigned u, v, f;
    bq.push_back(0);
    fail_nx[0] = 0;
    dict_nx[0] = 0;
    while (bq.size() > 0) begin
      u = bq.pop_front();
      for (int s = 0; s < mpsm_pkg::ALPHABET; s++) begin
        v = goto_nx[u*mpsm_pkg::ALPHABET+s];
        if (trie_edge(u, s, v)) begin
          f = (u != 0) ? goto_nx[fail_nx[u]*mpsm_pkg::ALPHABET+s] : 0;
          fail_nx[v] = f;
          dict_nx[v] = (hits[f] != 0) ? f : dict_nx[f];
          bq.push_back(v);
        end else begin
          goto_nx[u*mpsm_pkg::ALPHABET+s] =
            (u != 0) ? goto_nx[fail_nx[u]*mpsm_pkg::ALPHABET+s] : 0;
        end
      end
    end
    walk_node = 0;
    total_hits = 0;
  endfunction

  function automatic void predict_word(mpsm_pkg::mode_t mode, int unsigned sym, bit last);
    int unsigned v;
    int guard;
    total_t t;
    bit ok;
    ok = sym < mpsm_pkg::ALPHABET;
    case (mode)
      mpsm_pkg::MODE_PATTERN: begin
        if (ok && !drop_pat) begin
          v = goto_nx[put_node*mpsm_pkg::ALPHABET+sym];
          if (!trie_edge(put_node, sym, v)) begin
            if (used_nodes + 1 >= mpsm_pkg::NODES) begin
              trie_over = 1'b1;
              drop_pat = 1'b1;
            end else begin
              used_nodes++;
              v = used_nodes;
              up_node[v] = put_node;
              up_sym[v] = sym;
              goto_nx[put_node*mpsm_pkg::ALPHABET+sym] = v;
            end
          end
          if (!drop_pat) put_node = v;
        end
        if (last) begin
          if (!drop_pat && hits[put_node] < mpsm_pkg::END_MAX) hits[put_node]++;
          put_node = 0;
          drop_pat = 1'b0;
        end
      end
      mpsm_pkg::MODE_BUILD: build_links();
      mpsm_pkg::MODE_TEXT: begin
        if (ok) begin
          walk_node = goto_nx[walk_node*mpsm_pkg::ALPHABET+sym];
          take_hits(walk_node);
          v = dict_nx[walk_node];
          guard = 0;
          while (v != 0 && guard < mpsm_pkg::NODES) begin
            take_hits(v);
            v = dict_nx[v];
            guard++;
          end
        end
        if (last) begin
          t.count = mpsm_pkg::CNT_W'(total_hits);
          t.full = trie_over;
          totals_q.push_back(t);
          total_hits = 0;
          walk_node = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // send one word; bursts of random length separated by random gaps
  task automatic send_word(mpsm_pkg::mode_t mode, int unsigned sym, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, sym[4:0]};
    in_tuser  <= mode;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_word(mode, sym, last);
  endtask

  task automatic send_string(mpsm_pkg::mode_t mode, string s);
    for (int i = 0; i < s.len(); i++)
      send_word(mode, s[i] - "a", i == s.len() - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (totals_q.size() > 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_string(mpsm_pkg::MODE_TEXT, "he");          // text before any pattern
    send_string(mpsm_pkg::MODE_PATTERN, "he");
    send_string(mpsm_pkg::MODE_PATTERN, "she");
    send_string(mpsm_pkg::MODE_PATTERN, "he");       // duplicate pattern
    send_word(mpsm_pkg::MODE_PATTERN, 31, 1'b1);     // invalid letter only: bumps the root
    send_word(mpsm_pkg::MODE_NONE, 3, 1'b1);
    send_word(mpsm_pkg::MODE_BUILD, 0, 1'b0);
    send_word(mpsm_pkg::MODE_TEXT, 18, 1'b0);
    send_word(mpsm_pkg::MODE_TEXT, 26, 1'b0);        // ignored letter
    send_word(mpsm_pkg::MODE_TEXT, 7, 1'b0);
    send_word(mpsm_pkg::MODE_TEXT, 25, 1'b0);
    send_word(mpsm_pkg::MODE_TEXT, 4, 1'b1);
    send_string(mpsm_pkg::MODE_TEXT, "she");         // counts were consumed
    send_word(mpsm_pkg::MODE_TEXT, 30, 1'b1);        // invalid letter closes text
    drain();
  endtask

  task automatic test_random();
    int sent, len, alpha;
    sent = 0;
    while (sent < 600) begin
      alpha = ($urandom_range(0, 3) == 0) ? 32 : 4;
      repeat ($urandom_range(2, 6)) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_word(mpsm_pkg::MODE_PATTERN, $urandom_range(0, alpha - 1), i == len - 1);
          sent++;
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        send_word(mpsm_pkg::MODE_BUILD, $urandom_range(0, 31), $urandom_range(0, 1));
        sent++;
      end
      repeat ($urandom_range(1, 4)) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0)
            send_word(mpsm_pkg::MODE_NONE, $urandom_range(0, 31), $urandom_range(0, 1));
          else
            send_word(mpsm_pkg::MODE_TEXT, $urandom_range(0, alpha - 1), i == len - 1);
          sent++;
        end
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
    drain();
  endtask

  // receiver stall pattern: quiet stretches and busy stretches
  always @(posedge clk) begin
    rx_phase <= (rx_phase == 299) ? 0 : rx_phase + 1;
    if (rx_phase == 0) quiet_rx <= $urandom_range(0, 2) == 0;
    out_tready <= quiet_rx ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    total_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (totals_q.size() == 0) begin
        $error("unexpected result word: match_count %0d", out_tdata[19:0]);
        errors++;
      end else begin
        e = totals_q.pop_front();
        if (out_tdata[19:0] !== e.count) begin
          $error("match_count: expected %0d, got %0d", e.count, out_tdata[19:0]);
          errors++;
        end
        if (out_tdata[20] !== e.full) begin
          $error("trie_full: expected %0d, got %0d", e.full, out_tdata[20]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    used_nodes = 0; put_node = 0; walk_node = 0; total_hits = 0;
    trie_over = 1'b0; drop_pat = 1'b0;
    foreach (goto_nx[i]) goto_nx[i] = 0;
    for (int i = 0; i < mpsm_pkg::NODES; i++) begin
      fail_nx[i] = 0; dict_nx[i] = 0; hits[i] = 0; up_node[i] = 0; up_sym[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    repeat (TAIL_WAIT) @(posedge clk);
    if (errors == 0 && totals_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
